FILE: src/fpr_pkg.sv
// Package for the Fermat primality round block.
// Holds the default word width, the verdict codes and the sequencer state type.
package fpr_pkg;

   localparam int WORD_BITS_DEFAULT = 31;

   typedef enum logic [1:0] {
      CODE_PASS   = 2'd0,
      CODE_SMALL  = 2'd1,
      CODE_FACTOR = 2'd2,
      CODE_FERMAT = 2'd3
   } code_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_CHK  = 7'b0000010,
      ST_BASE = 7'b0000100,
      ST_GCD  = 7'b0001000,
      ST_PSQ  = 7'b0010000,
      ST_PML  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

endpackage

FILE: src/fermat_primality_round.sv
// Fermat primality round: one probable-prime round per input beat.
// Uses fpr_pkg for verdict codes and sequencer states.
//
// Usage: req_ beats carry candidate n, a random word and a last_round flag.
// Each beat is one round with base a = 2 + (word mod (n-4)). The round fails
// if gcd(n, a) != 1 or a^(n-1) mod n != 1; n <= 1 and n == 4 fail as small
// values, n == 2 and n == 3 pass. Failures are ORed over the rounds of one
// candidate, and the first failure code is kept. A beat with last_round set
// produces one rsp_ beat with the verdict and clears the stored flag.
// All arithmetic runs through one shared double-and-add modular unit that
// handles one bit of a remainder or a modular product per cycle.
// Per round: small values are settled in ST_CHK; otherwise the unit first
// reduces the word to the base, then runs the Euclid steps (up to about
// 45 steps), then the modular power by modular multiplies, one square per
// exponent bit plus one multiply per set bit.
// req_stall is high from acceptance until the round is done; one beat at
// a time. The verdict sits in the output register while rsp_stall is high
// and the next rounds go on; only a verdict that finishes while the register
// is still full holds the sequencer, and req_stall, until it drains.
// Reset (synchronous) clears the sequencer, the failure flag and rsp_valid.
module fermat_primality_round #(
   parameter int WORD_BITS = fpr_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_candidate,
   input  logic [WORD_BITS-1:0] req_random_word,
   input  logic                 req_last_round,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_is_probable_prime,
   output logic [1:0]           rsp_verdict_code
);
   import fpr_pkg::*;

   localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam logic [CW-1:0] CNT_TOP = CW'(WORD_BITS - 1);

   state_type state_ff, state_in;
   logic [WORD_BITS-1:0] n_ff, n_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] mod_ff, mod_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] div_ff, div_in;
   logic [WORD_BITS-1:0] opnd_ff, opnd_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        ebit_ff, ebit_in;
   logic                 last_ff, last_in;
   logic                 seen_ff, seen_in;
   code_type             kind_ff, kind_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 prime_ff, prime_in;
   code_type             vcode_ff, vcode_in;

   // shared unit: acc = (2*acc + add) mod mod_ff, add <= mod_ff
   logic [WORD_BITS:0]   dbl, s1, t2;
   logic [WORD_BITS-1:0] addend, step_res, exp_w;
   logic                 round_done;
   logic                 out_free;
   code_type             round_code;

   always_comb begin
      dbl = {acc_ff, 1'b0};
      s1  = (dbl >= {1'b0, mod_ff}) ? dbl - {1'b0, mod_ff} : dbl;
      if (!div_ff[WORD_BITS-1])
         addend = '0;
      else if (state_ff == ST_PSQ || state_ff == ST_PML)
         addend = opnd_ff;
      else
         addend = WORD_BITS'(1);
      t2  = {1'b0, s1[WORD_BITS-1:0]} + {1'b0, addend};
      step_res = (t2 >= {1'b0, mod_ff}) ? WORD_BITS'(t2 - {1'b0, mod_ff})
                                        : t2[WORD_BITS-1:0];
   end

   assign exp_w    = n_ff - WORD_BITS'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      mod_in       = mod_ff;
      acc_in       = acc_ff;
      div_in       = div_ff;
      opnd_in      = opnd_ff;
      cnt_in       = cnt_ff;
      ebit_in      = ebit_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      prime_in     = prime_ff;
      vcode_in     = vcode_ff;
      round_done   = 1'b0;
      round_code   = CODE_PASS;

      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in     = req_candidate;
               div_in   = req_random_word;
               last_in  = req_last_round;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (n_ff <= WORD_BITS'(1) || n_ff == WORD_BITS'(4)) begin
               round_done = 1'b1;
               round_code = CODE_SMALL;
            end else if (n_ff <= WORD_BITS'(3)) begin
               round_done = 1'b1;
            end else begin
               mod_in   = n_ff - WORD_BITS'(4);
               acc_in   = '0;
               cnt_in   = CNT_TOP;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            acc_in = step_res;
            div_in = div_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               base_in  = step_res + WORD_BITS'(2);
               mod_in   = step_res + WORD_BITS'(2);
               div_in   = n_ff;
               acc_in   = '0;
               cnt_in   = CNT_TOP;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            acc_in = step_res;
            div_in = div_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               if (step_res == '0) begin
                  // mod_ff holds the gcd
                  if (mod_ff != WORD_BITS'(1)) begin
                     round_done = 1'b1;
                     round_code = CODE_FACTOR;
                  end else begin
                     mod_in   = n_ff;
                     div_in   = WORD_BITS'(1);
                     opnd_in  = WORD_BITS'(1);
                     acc_in   = '0;
                     cnt_in   = CNT_TOP;
                     ebit_in  = CNT_TOP;
                     state_in = ST_PSQ;
                  end
               end else begin
                  mod_in = step_res;
                  div_in = mod_ff;
                  acc_in = '0;
                  cnt_in = CNT_TOP;
               end
            end
         end
         ST_PSQ, ST_PML: begin
            acc_in = step_res;
            div_in = div_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               acc_in = '0;
               cnt_in = CNT_TOP;
               div_in = step_res;
               if (state_ff == ST_PSQ && exp_w[ebit_ff]) begin
                  opnd_in  = base_ff;
                  state_in = ST_PML;
               end else if (ebit_ff == '0) begin
                  round_done = 1'b1;
                  round_code = (step_res == WORD_BITS'(1)) ? CODE_PASS : CODE_FERMAT;
               end else begin
                  ebit_in  = ebit_ff - CW'(1);
                  opnd_in  = step_res;
                  state_in = ST_PSQ;
               end
            end
         end
         ST_OUT: begin
            // verdict ready but the previous one is still held
            if (out_free) begin
               rsp_valid_in = 1'b1;
               prime_in     = !seen_ff;
               vcode_in     = kind_ff;
               seen_in      = 1'b0;
               kind_in      = CODE_PASS;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (round_done) begin
         if (round_code != CODE_PASS && !seen_ff) begin
            seen_in = 1'b1;
            kind_in = round_code;
         end
         if (last_ff && out_free) begin
            rsp_valid_in = 1'b1;
            prime_in     = !seen_in;
            vcode_in     = kind_in;
            seen_in      = 1'b0;
            kind_in      = CODE_PASS;
            state_in     = ST_IDLE;
         end else if (last_ff) begin
            state_in = ST_OUT;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         kind_ff      <= CODE_PASS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff     <= n_in;
      base_ff  <= base_in;
      mod_ff   <= mod_in;
      acc_ff   <= acc_in;
      div_ff   <= div_in;
      opnd_ff  <= opnd_in;
      cnt_ff   <= cnt_in;
      ebit_ff  <= ebit_in;
      last_ff  <= last_in;
      prime_ff <= prime_in;
      vcode_ff <= vcode_in;
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_is_probable_prime = prime_ff;
   assign rsp_verdict_code      = vcode_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable(prime_ff) && $stable(vcode_ff)))
      else $error("stalled verdict beat changed");

   a_accept_chk: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CHK))
      else $error("accepted beat did not start a round");

   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (prime_ff == (vcode_ff == CODE_PASS)))
      else $error("verdict flag and code disagree");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD || state_ff == ST_PSQ || state_ff == ST_PML)
         |-> (acc_ff < mod_ff))
      else $error("shared unit accumulator not reduced");

endmodule
